[rtl/core/rqps_pkg.sv]
// Shared types and codes for the ready queue policy selector.
// No dependencies; imported by the core and its tests.
package rqps_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;
	localparam int OCC_W = 5;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic CMD_ENQUEUE  = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	localparam logic [1:0] POL_ARRIVAL   = 2'd0;
	localparam logic [1:0] POL_BURST     = 2'd1;
	localparam logic [1:0] POL_REMAINING = 2'd2;
	localparam logic [1:0] POL_HEAD      = 2'd3;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
	} entry_t;

endpackage

[rtl/core/ready_queue_policy_selector_core.sv]
// Ready queue with policy-based dispatch: entries live in one RAM (rqps_ram),
// control and types come from rqps_pkg.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, command, task_id,     | into block
//          | arrival_time, burst_length, remaining_time|
//  out     | out_valid, out_stall, status, chosen_id,  | out of block
//          | chosen_burst, chosen_remaining, occupancy |
//  cfg     | cfg_wr_en, cfg_wr_data (policy_mode)      | into block
//
// Enqueue, full and empty cases go from accept through the finish state to the
// result register. A dispatch scans the entries (one read a cycle, through the
// registered RAM read; the head policy reads entry zero only), then moves each entry
// above the chosen one down a slot to close the gap (none when the last entry goes)
// and then loads the result; the single RAM read port serializes scan and compaction.
// Reset clears the count, the policy and all control; RAM contents are unused
// until written. A new item is taken while a finished result waits, and a
// stalled result holds in the output register; the next result waits for it.
module ready_queue_policy_selector_core #(
	parameter int QUEUE_DEPTH = rqps_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [1:0]                 cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [7:0]                 task_id,
	input  logic [15:0]                arrival_time,
	input  logic [15:0]                burst_length,
	input  logic [15:0]                remaining_time,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [7:0]                 chosen_id,
	output logic [15:0]                chosen_burst,
	output logic [15:0]                chosen_remaining,
	output logic [rqps_pkg::OCC_W-1:0] occupancy
);

	import rqps_pkg::*;

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_SHIFT  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       policy_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic             rd_vld_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [15:0]      best_key_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic [1:0]       stat_q;
	entry_t           pick_q;
	logic             out_valid_q;

	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;
	logic [CNT_W-1:0] scan_lim;
	logic [CNT_W-1:0] rd_lim;
	logic             rd_issue;
	logic [15:0]      rd_key;
	logic             take;
	logic [ADDR_W-1:0] best_idx_d;
	logic             scan_last;
	logic             accept;
	logic             out_free;

	rqps_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_ptr_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Head policy only needs entry zero.
	assign scan_lim = (policy_q == POL_HEAD) ? CNT_W'(1) : count_q;
	assign rd_lim   = (state_q == ST_SCAN) ? scan_lim : count_q;
	assign rd_issue = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_ptr_q < rd_lim);

	always_comb begin
		case (policy_q)
			POL_ARRIVAL: rd_key = ram_rdata.arrival;
			POL_BURST:   rd_key = ram_rdata.burst;
			default:     rd_key = ram_rdata.remaining;
		endcase
	end

	// Strict less-than keeps the earliest entry on a tie.
	assign take = (state_q == ST_SCAN) && rd_vld_s1 &&
		((rd_idx_s1 == '0) || (rd_key < best_key_q));
	assign best_idx_d = take ? rd_idx_s1 : best_idx_q;
	assign scan_last  = (state_q == ST_SCAN) && rd_vld_s1 &&
		(CNT_W'(rd_idx_s1) == scan_lim - CNT_W'(1));

	// Enqueue writes at the tail; compaction writes each entry one slot down.
	// During compaction reads run ahead of writes, so no address is read and written at once.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = '{id: task_id, arrival: arrival_time,
			burst: burst_length, remaining: remaining_time};
		if (state_q == ST_SHIFT) begin
			ram_we    = rd_vld_s1;
			ram_waddr = rd_idx_s1 - ADDR_W'(1);
			ram_wdata = ram_rdata;
		end else if (accept && command == CMD_ENQUEUE && count_q < DEPTH_C) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			policy_q    <= POL_ARRIVAL;
			rd_ptr_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				policy_q <= cfg_wr_data;
			end
			// The last scan read has already gone out, so this drops to zero on leaving the scan.
			rd_vld_s1 <= rd_issue;
			if (rd_issue) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == CMD_DISPATCH && count_q != '0) begin
							state_q  <= ST_SCAN;
							rd_ptr_q <= '0;
						end else begin
							state_q <= ST_FINISH;
							if (command == CMD_ENQUEUE && count_q < DEPTH_C) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q  <= ST_SHIFT;
						rd_ptr_q <= CNT_W'(best_idx_d) + CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					if (!rd_issue && !rd_vld_s1) begin
						state_q <= ST_FINISH;
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr_q[ADDR_W-1:0];
		if (take) begin
			best_key_q <= rd_key;
			best_idx_q <= rd_idx_s1;
			pick_q     <= ram_rdata;
		end
		if (accept) begin
			pick_q <= '0;
			if (command == CMD_ENQUEUE) begin
				stat_q <= (count_q < DEPTH_C) ? STAT_DONE : STAT_FULL;
			end else begin
				stat_q <= (count_q != '0) ? STAT_DONE : STAT_EMPTY;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			status           <= stat_q;
			chosen_id        <= pick_q.id;
			chosen_burst     <= pick_q.burst;
			chosen_remaining <= pick_q.remaining;
			occupancy        <= OCC_W'(count_q);
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count above depth");

	a_shift_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && ram_we) |-> (CNT_W'(ram_waddr) < count_q))
		else $error("compaction write beyond occupied entries");

	a_empty_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_DISPATCH && count_q == '0)
		|=> (state_q == ST_FINISH && stat_q == STAT_EMPTY))
		else $error("empty dispatch not reported");

	a_read_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_SHIFT))
		else $error("RAM read data returned outside scan or compaction");

	a_finish_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not loaded on finish");

endmodule

[rtl/core/rqps_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rqps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/sv/rqps_tb_pkg.sv]
// Scoreboard for the ready queue policy selector: predicts each outcome and checks results.
// Depends on rqps_pkg for the entry type and the status, command and policy codes.
package rqps_tb_pkg;
	import rqps_pkg::*;

	typedef struct {
		logic [1:0]       status;
		logic [7:0]       id;
		logic [15:0]      burst;
		logic [15:0]      remaining;
		logic [OCC_W-1:0] occupancy;
	} outcome_t;

	class dispatch_scoreboard;
		int unsigned depth;
		logic [1:0]  policy;
		entry_t      held_tasks[$];
		outcome_t    awaited_outcomes[$];
		int unsigned errors;

		function new(int unsigned queue_depth);
			depth = queue_depth;
			policy = POL_ARRIVAL;
			errors = 0;
		endfunction

		function void set_policy(logic [1:0] mode);
			policy = mode;
		endfunction

		function int unsigned pending();
			return awaited_outcomes.size();
		endfunction

		function logic [15:0] key_of(entry_t e);
			case (policy)
				POL_ARRIVAL: return e.arrival;
				POL_BURST:   return e.burst;
				default:     return e.remaining;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// Apply one accepted item to the shadow queue and store the outcome it should give.
		function void note_command(logic cmd, entry_t e);
			outcome_t o;
			int       sel;
			int       i;
			o.status = STAT_DONE;
			o.id = '0;
			o.burst = '0;
			o.remaining = '0;
			if (cmd == CMD_ENQUEUE) begin
				if (held_tasks.size() >= depth)
					o.status = STAT_FULL;
				else
					held_tasks.insert(held_tasks.size(), e);
			end else if (held_tasks.size() == 0) begin
				o.status = STAT_EMPTY;
			end else begin
				sel = 0;
				// strict less-than keeps the entry nearest the head on a tie
				if (policy != POL_HEAD) begin
					for (i = 1; i < held_tasks.size(); i++)
						if (key_of(held_tasks[i]) < key_of(held_tasks[sel]))
							sel = i;
				end
				o.id = held_tasks[sel].id;
				o.burst = held_tasks[sel].burst;
				o.remaining = held_tasks[sel].remaining;
				held_tasks.delete(sel);
			end
			o.occupancy = OCC_W'(held_tasks.size());
			awaited_outcomes.insert(awaited_outcomes.size(), o);
		endfunction

		task check_outcome(outcome_t got);
			outcome_t want;
			if (awaited_outcomes.size() == 0) begin
				report_mismatch("result with no item outstanding");
				return;
			end
			want = awaited_outcomes.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.id !== want.id)
				report_mismatch($sformatf("chosen_id %02h, want %02h", got.id, want.id));
			if (got.burst !== want.burst)
				report_mismatch($sformatf("chosen_burst %04h, want %04h", got.burst,
					want.burst));
			if (got.remaining !== want.remaining)
				report_mismatch($sformatf("chosen_remaining %04h, want %04h", got.remaining,
					want.remaining));
			if (got.occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy %0d, want %0d", got.occupancy,
					want.occupancy));
		endtask
	endclass

endpackage

[tb/sv/tb_ready_queue_policy_selector_core.sv]
// Top-level test of ready_queue_policy_selector_core: directed and random enqueue/dispatch
// traffic under all four policies, with bursty sending and receiver back-pressure.
// Depends on rqps_pkg and rqps_tb_pkg.
module tb_ready_queue_policy_selector_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rqps_pkg::*;
	import rqps_tb_pkg::*;

	localparam int DEPTH          = DEFAULT_QUEUE_DEPTH;
	localparam int RANDOM_ITEMS   = 600;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT     = 4000;
	localparam int TAIL_CYCLES    = 2 * DEPTH + 8;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [1:0]       cfg_wr_data;
	logic             in_valid;
	logic             in_stall;
	logic             command;
	logic [7:0]       task_id;
	logic [15:0]      arrival_time;
	logic [15:0]      burst_length;
	logic [15:0]      remaining_time;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       status;
	logic [7:0]       chosen_id;
	logic [15:0]      chosen_burst;
	logic [15:0]      chosen_remaining;
	logic [OCC_W-1:0] occupancy;

	dispatch_scoreboard sb;
	bit                 rx_hold_req;
	int                 idle_cycles;

	ready_queue_policy_selector_core #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.task_id(task_id),
		.arrival_time(arrival_time),
		.burst_length(burst_length),
		.remaining_time(remaining_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.chosen_id(chosen_id),
		.chosen_burst(chosen_burst),
		.chosen_remaining(chosen_remaining),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic entry_t task_entry(logic [7:0] id, logic [15:0] arr, logic [15:0] bur,
		logic [15:0] rem);
		entry_t e;
		e.id = id;
		e.arrival = arr;
		e.burst = bur;
		e.remaining = rem;
		return e;
	endfunction

	// Bias keys towards extremes and a narrow band so ties turn up often.
	function automatic logic [15:0] rand_key();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3, 4: return 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic entry_t rand_entry();
		return task_entry(8'($urandom), rand_key(), rand_key(), rand_key());
	endfunction

	// Present one item from a falling edge and hold it until accepted.
	task automatic offer(logic cmd, entry_t e);
		command <= cmd;
		task_id <= e.id;
		arrival_time <= e.arrival;
		burst_length <= e.burst;
		remaining_time <= e.remaining;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_command(cmd, e);
		@(negedge clk);
	endtask

	task automatic idle_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_policy(logic [1:0] mode);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_policy(mode);
	endtask

	// Receiver: stall pattern of its own, plus one long hold-off on request.
	initial begin
		int seg_left;
		int stall_pct;
		seg_left = 0;
		stall_pct = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 120);
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 20;
					default: stall_pct = 60;
				endcase
			end
			seg_left--;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status;
			got.id = chosen_id;
			got.burst = chosen_burst;
			got.remaining = chosen_remaining;
			got.occupancy = occupancy;
			sb.check_outcome(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int          issued;
		int          phase;
		int          len;
		int          enq_pct;
		int          burst_left;
		bit          gaps_on;
		logic        cmd;
		logic [1:0]  mode;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		command = CMD_ENQUEUE;
		task_id = '0;
		arrival_time = '0;
		burst_length = '0;
		remaining_time = '0;
		rx_hold_req = 1'b0;
		idle_cycles = 0;
		sb = new(DEPTH);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty dispatch with noise in the entry fields, extremes, ties, each policy.
		offer(CMD_DISPATCH, task_entry(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer(CMD_ENQUEUE, task_entry(8'h00, 16'hFFFF, 16'h0000, 16'hFFFF));
		offer(CMD_ENQUEUE, task_entry(8'hFF, 16'h0000, 16'hFFFF, 16'h0000));
		offer(CMD_ENQUEUE, task_entry(8'h5A, 16'h0000, 16'h0000, 16'h0000));
		offer(CMD_ENQUEUE, task_entry(8'hA5, 16'h1234, 16'h0000, 16'h8000));
		offer(CMD_DISPATCH, rand_entry());
		write_policy(POL_BURST);
		offer(CMD_DISPATCH, rand_entry());
		write_policy(POL_REMAINING);
		offer(CMD_DISPATCH, rand_entry());
		write_policy(POL_HEAD);
		offer(CMD_DISPATCH, rand_entry());
		// fill to the brim, then one more enqueue to hit the full case
		repeat (DEPTH + 1) offer(CMD_ENQUEUE, rand_entry());

		// Random phases: vary policy, enqueue mix, sender gaps.
		issued = 0;
		phase = 0;
		while (issued < RANDOM_ITEMS) begin
			mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
			write_policy(mode);
			case ($urandom_range(0, 2))
				0:       enq_pct = 85;
				1:       enq_pct = 50;
				default: enq_pct = 20;
			endcase
			gaps_on = (phase % 3 != 1);
			if (phase == 2) begin
				// hold the receiver off while items keep coming
				enq_pct = 85;
				gaps_on = 1'b0;
				rx_hold_req = 1'b1;
			end
			len = $urandom_range(30, 70);
			burst_left = $urandom_range(1, 12);
			repeat (len) begin
				cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DISPATCH;
				offer(cmd, rand_entry());
				issued++;
				if (gaps_on) begin
					burst_left--;
					if (burst_left == 0) begin
						idle_sender($urandom_range(1, 8));
						burst_left = $urandom_range(1, 12);
					end
				end
			end
			phase++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		while (sb.pending() != 0) begin
			sb.report_mismatch("expected result never arrived");
			void'(sb.awaited_outcomes.pop_front());
		end
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
